>>> rtl/bgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register indexes and gesture codes for the button gesture
// classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned LimitW = 16;
	localparam int unsigned RegIdxW = 3;

	// Register indexes on the write port
	localparam logic [RegIdxW-1:0] RegShortMin   = 3'd0;
	localparam logic [RegIdxW-1:0] RegShortMax   = 3'd1;
	localparam logic [RegIdxW-1:0] RegLongMin    = 3'd2;
	localparam logic [RegIdxW-1:0] RegLongTimeout = 3'd3;
	localparam logic [RegIdxW-1:0] RegGapMax     = 3'd4;

	// Register reset values
	localparam logic [LimitW-1:0] ShortMinRst    = 16'd50;
	localparam logic [LimitW-1:0] ShortMaxRst    = 16'd500;
	localparam logic [LimitW-1:0] LongMinRst     = 16'd1000;
	localparam logic [LimitW-1:0] LongTimeoutRst = 16'd15000;
	localparam logic [LimitW-1:0] GapMaxRst      = 16'd500;

	typedef enum logic [2:0] {
		GEST_NONE       = 3'd0,
		GEST_SHORT      = 3'd1,
		GEST_LONG       = 3'd2,
		GEST_PRESS_LONG = 3'd3,
		GEST_DBL_LONG   = 3'd4
	} gesture_t;

	typedef struct packed {
		logic [LimitW-1:0] short_min_ms;
		logic [LimitW-1:0] short_max_ms;
		logic [LimitW-1:0] long_min_ms;
		logic [LimitW-1:0] long_timeout_ms;
		logic [LimitW-1:0] gap_max_ms;
	} cfg_t;

	typedef struct packed {
		gesture_t gesture;
		logic     gesture_changed;
		logic     pair_mode;
	} result_t;

	// Strict window test: lo < v < hi
	function automatic logic in_window(input logic [TimeW-1:0] v,
			input logic [LimitW-1:0] lo, input logic [LimitW-1:0] hi);
		logic [TimeW-1:0] lo_x;
		logic [TimeW-1:0] hi_x;
		lo_x = {{(TimeW-LimitW){1'b0}}, lo};
		hi_x = {{(TimeW-LimitW){1'b0}}, hi};
		return (v > lo_x) && (v < hi_x);
	endfunction

endpackage

>>> rtl/bgc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_scan_if / bgc_result_if
// Valid/ready channels for button scans in and gesture results out.
// ----------------------------------------------------------------------------
interface bgc_scan_if;
	logic                       valid;
	logic                       ready;
	logic                       pin_level;
	logic [bgc_pkg::TimeW-1:0]  now_ms;

	modport source (output valid, output pin_level, output now_ms, input ready);
	modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bgc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] gesture;
	logic       gesture_changed;
	logic       pair_mode;

	modport source (output valid, output gesture, output gesture_changed,
		output pair_mode, input ready);
	modport sink   (input valid, input gesture, input gesture_changed,
		input pair_mode, output ready);
endinterface

>>> rtl/bgc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Five 16-bit timing limits written through a plain indexed write port.
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bgc_pkg::RegIdxW-1:0]   wr_index,
	input  logic [bgc_pkg::LimitW-1:0]    wr_data,
	output bgc_pkg::cfg_t                 cfg
);

	bgc_pkg::cfg_t cfg_q;

	// Update the addressed limit; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min_ms    <= bgc_pkg::ShortMinRst;
			cfg_q.short_max_ms    <= bgc_pkg::ShortMaxRst;
			cfg_q.long_min_ms     <= bgc_pkg::LongMinRst;
			cfg_q.long_timeout_ms <= bgc_pkg::LongTimeoutRst;
			cfg_q.gap_max_ms      <= bgc_pkg::GapMaxRst;
		end else if (wr_en) begin
			case (wr_index)
				bgc_pkg::RegShortMin:    cfg_q.short_min_ms    <= wr_data;
				bgc_pkg::RegShortMax:    cfg_q.short_max_ms    <= wr_data;
				bgc_pkg::RegLongMin:     cfg_q.long_min_ms     <= wr_data;
				bgc_pkg::RegLongTimeout: cfg_q.long_timeout_ms <= wr_data;
				bgc_pkg::RegGapMax:      cfg_q.gap_max_ms      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bgc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_classify
// Press history state and single-pass gesture classification of one scan.
// ----------------------------------------------------------------------------
module bgc_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       pin_level,
	input  logic [bgc_pkg::TimeW-1:0]  now_ms,
	input  bgc_pkg::cfg_t              cfg,
	output bgc_pkg::result_t           res
);

	logic                      is_pressed_q;
	logic [bgc_pkg::TimeW-1:0] rise_newest_q;
	logic [bgc_pkg::TimeW-1:0] rise_middle_q;
	logic [bgc_pkg::TimeW-1:0] rise_oldest_q;
	bgc_pkg::gesture_t         last_gesture_q;
	logic                      pairing_q;

	logic                      pressed;
	logic                      rising;
	logic [bgc_pkg::TimeW-1:0] rise_newest_d;
	logic [bgc_pkg::TimeW-1:0] rise_middle_d;
	logic [bgc_pkg::TimeW-1:0] rise_oldest_d;
	logic [bgc_pkg::TimeW-1:0] hold;
	logic [bgc_pkg::TimeW-1:0] gap1;
	logic [bgc_pkg::TimeW-1:0] gap2;
	logic                      is_short;
	logic                      is_long;
	logic                      pre;
	logic                      dbl;
	bgc_pkg::gesture_t         gesture;
	logic                      changed;
	logic                      pairing_d;

	// Shift rise timestamps on a press edge, then take wrapping differences.
	// The stored level is the previous pressed level of the scan in hand.
	always_comb begin
		pressed = ~pin_level;
		rising  = ~is_pressed_q & pressed;
		rise_newest_d = rising ? now_ms        : rise_newest_q;
		rise_middle_d = rising ? rise_newest_q : rise_middle_q;
		rise_oldest_d = rising ? rise_middle_q : rise_oldest_q;
		hold = now_ms - rise_newest_d;
		gap1 = rise_newest_d - rise_middle_d;
		gap2 = rise_middle_d - rise_oldest_d;
	end

	// Classify against the configured windows
	always_comb begin
		is_short = is_pressed_q & ~pressed &
			bgc_pkg::in_window(hold, cfg.short_min_ms, cfg.short_max_ms);
		is_long  = pressed &
			bgc_pkg::in_window(hold, cfg.long_min_ms, cfg.long_timeout_ms);
		pre = (is_short | is_long) &
			bgc_pkg::in_window(gap1, cfg.short_min_ms, cfg.gap_max_ms);
		dbl = pre & bgc_pkg::in_window(gap2, cfg.short_min_ms, cfg.gap_max_ms);

		if (!pre && is_short) begin
			gesture = bgc_pkg::GEST_SHORT;
		end else if (is_long) begin
			gesture = dbl ? bgc_pkg::GEST_DBL_LONG :
				(pre ? bgc_pkg::GEST_PRESS_LONG : bgc_pkg::GEST_LONG);
		end else begin
			gesture = bgc_pkg::GEST_NONE;
		end

		changed = (gesture != last_gesture_q);

		// Set pairing on a change to press+long, drop it on a change to none
		pairing_d = pairing_q;
		if (changed && gesture == bgc_pkg::GEST_PRESS_LONG) begin
			pairing_d = 1'b1;
		end else if (changed && gesture == bgc_pkg::GEST_NONE) begin
			pairing_d = 1'b0;
		end

		res.gesture         = gesture;
		res.gesture_changed = changed;
		res.pair_mode       = pairing_d;
	end

	// Commit history when a scan is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q   <= 1'b0;
			rise_newest_q  <= '0;
			rise_middle_q  <= '0;
			rise_oldest_q  <= '0;
			last_gesture_q <= bgc_pkg::GEST_NONE;
			pairing_q      <= 1'b0;
		end else if (step) begin
			is_pressed_q   <= pressed;
			rise_newest_q  <= rise_newest_d;
			rise_middle_q  <= rise_middle_d;
			rise_oldest_q  <= rise_oldest_d;
			last_gesture_q <= gesture;
			pairing_q      <= pairing_d;
		end
	end

endmodule

>>> rtl/button_gesture_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies button scans into none, short, long, press+long and
// double+long gestures, with a pairing-mode flag.
// ----------------------------------------------------------------------------
// Each scan transfer gives exactly one result transfer. The block takes one
// scan per clock: a scan is held in an input register, classified by one
// short pass of subtractions and window compares against the press history,
// and the result is loaded into an output register once that register is free
// or being drained. The history advances as the result register is
// loaded, so a new scan may follow every cycle; a stalled result register
// holds the input stage and back-pressures the scan channel. Limits are
// written through wr_en/wr_index/wr_data while no scan is in flight.
module button_gesture_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	bgc_scan_if.sink                      scan,
	bgc_result_if.source                  result,
	input  logic                          wr_en,
	input  logic [bgc_pkg::RegIdxW-1:0]   wr_index,
	input  logic [bgc_pkg::LimitW-1:0]    wr_data
);

	bgc_pkg::cfg_t             cfg;
	bgc_pkg::result_t          res;
	logic                      valid_s1;
	logic                      pin_level_s1;
	logic [bgc_pkg::TimeW-1:0] now_ms_s1;
	logic                      valid_s2;
	bgc_pkg::result_t          res_s2;
	logic                      advance;
	logic                      take_scan;

	bgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Move the held scan on when the result register is free or being drained
	assign advance   = valid_s1 & (~valid_s2 | result.ready);
	assign scan.ready = ~valid_s1 | advance;
	assign take_scan = scan.valid & scan.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_scan) begin
			pin_level_s1 <= scan.pin_level;
			now_ms_s1    <= scan.now_ms;
		end
	end

	bgc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_level_s1),
		.now_ms    (now_ms_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid           = valid_s2;
	assign result.gesture         = res_s2.gesture;
	assign result.gesture_changed = res_s2.gesture_changed;
	assign result.pair_mode       = res_s2.pair_mode;

endmodule
